/* design/assert_macros.svh */
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define LTT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define LTT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/lttk_pkg.sv */
// Types, constants and helper functions for the lambda term tokenizer.
`default_nettype none

package lttk_pkg;

  localparam int MAX_NAME_CHARS = 8;
  localparam int NAME_CNT_W     = 4;
  localparam int TEXT_W         = 64;

  localparam logic [7:0] END_CHAR_RESET = 8'd10;

  localparam logic [2:0] KIND_LPAREN  = 3'd0;
  localparam logic [2:0] KIND_RPAREN  = 3'd1;
  localparam logic [2:0] KIND_DOT     = 3'd2;
  localparam logic [2:0] KIND_BSLASH  = 3'd3;
  localparam logic [2:0] KIND_IDENT   = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;
  localparam logic [2:0] KIND_BADCHAR = 3'd6;
  localparam logic [2:0] KIND_TOOLONG = 3'd7;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  typedef struct packed {
    logic [2:0]            kind;
    logic [TEXT_W-1:0]     text;
    logic [NAME_CNT_W-1:0] len;
    logic [7:0]            bad;
    logic                  last;
  } token_t;

  typedef struct packed {
    logic [MAX_NAME_CHARS-1:0][7:0] chars;
    logic [NAME_CNT_W-1:0]          count;
    logic                           failed;
  } name_state_t;

  typedef struct packed {
    logic [1:0] n;
    token_t     first;
    token_t     second;
  } step_out_t;

  function automatic logic is_alnum(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic token_t flush_token(input name_state_t s);
    token_t                t;
    logic                  too_long;
    logic [NAME_CNT_W-1:0] len;
    t        = '0;
    too_long = (s.count > NAME_CNT_W'(MAX_NAME_CHARS));
    len      = too_long ? NAME_CNT_W'(MAX_NAME_CHARS) : s.count;
    for (int i = 0; i < MAX_NAME_CHARS; i++) begin
      if (NAME_CNT_W'(i) < len) begin
        t.text[8*i +: 8] = s.chars[i];
      end
    end
    t.kind = too_long ? KIND_TOOLONG : KIND_IDENT;
    t.len  = len;
    return t;
  endfunction

endpackage

`default_nettype wire

/* design/lambda_term_tokenizer_core.sv */
// Top level of the lambda term tokenizer: input register, name state and output queue.
`default_nettype none

`include "assert_macros.svh"

// Takes one byte per cycle while in_stall is low and emits lambda-calculus
// tokens (parens, dot, backslash, identifiers up to eight characters, end, and
// two error kinds). A byte is held in the input register, then the step logic
// updates the name state and pushes zero, one or two tokens into a four-entry
// output queue, whose head is offered while out_valid is high. Input is taken
// every cycle while the queue holds two or fewer tokens, so the rate is one
// byte per cycle as long as the output side drains one token per cycle; a byte
// that yields two tokens costs the output side an extra pop. The end byte is
// set through cfg_wr_en/cfg_wr_data, written only while idle by the user; the
// block does not enforce this.
module lambda_term_tokenizer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       token_kind,
  output logic [63:0]      name_text,
  output logic [3:0]       name_length,
  output logic [7:0]       bad_byte,
  output logic             last
);

  logic                  in_full;
  logic                  in_full_next;
  logic [7:0]            in_hold;
  logic [7:0]            end_char;
  lttk_pkg::name_state_t state;
  lttk_pkg::name_state_t state_next;
  lttk_pkg::step_out_t   step_res;
  lttk_pkg::token_t      head;
  logic                  room;
  logic                  not_empty;
  logic                  fire;
  logic                  in_take;
  logic                  pop;
  logic [1:0]            push_n;

  assign fire     = in_full && room;
  assign in_stall = rst || (in_full && !room);
  assign in_take  = in_valid && !in_stall;
  assign push_n   = fire ? step_res.n : 2'd0;

  assign out_valid = not_empty && !rst;
  assign pop       = out_valid && !out_stall;

  assign token_kind  = head.kind;
  assign name_text   = head.text;
  assign name_length = head.len;
  assign bad_byte    = head.bad;
  assign last        = head.last;

  always_comb begin
    in_full_next = in_full;
    if (in_take) begin
      in_full_next = 1'b1;
    end else if (fire) begin
      in_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      end_char <= lttk_pkg::END_CHAR_RESET;
      state    <= '0;
    end else begin
      in_full <= in_full_next;
      if (cfg_wr_en) begin
        end_char <= cfg_wr_data;
      end
      if (fire) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_hold <= in_byte;
    end
  end

  lttk_step u_step (
    .in_byte  (in_hold),
    .end_char (end_char),
    .cur      (state),
    .nxt      (state_next),
    .res      (step_res)
  );

  lttk_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_a    (step_res.first),
    .push_b    (step_res.second),
    .pop       (pop),
    .room      (room),
    .not_empty (not_empty),
    .head      (head)
  );

  `LTT_ASSERT_ALWAYS(a_count_sat, state.count <= lttk_pkg::NAME_CNT_W'(lttk_pkg::MAX_NAME_CHARS + 1), "name count past saturation")
  `LTT_ASSERT_IMPLIES(a_failed_quiet, fire && state.failed && (in_hold != end_char), push_n == 2'd0, "token while failed")
  `LTT_ASSERT_NEXT(a_end_clears, fire && (in_hold == end_char), !state.failed && (state.count == '0), "end byte left state")

endmodule

`default_nettype wire

/* design/lttk_step.sv */
// Per-byte tokenizer step: next name state and up to two tokens.
`default_nettype none

module lttk_step (
  input  wire logic [7:0]          in_byte,
  input  wire logic [7:0]          end_char,
  input  wire lttk_pkg::name_state_t cur,
  output lttk_pkg::name_state_t    nxt,
  output lttk_pkg::step_out_t      res
);

  lttk_pkg::token_t fl;
  lttk_pkg::token_t sym;
  lttk_pkg::token_t endt;
  logic             sym_v;
  logic             has_name;
  logic             too_long;

  always_comb begin
    nxt      = cur;
    res      = '0;
    fl       = lttk_pkg::flush_token(cur);
    has_name = (cur.count != '0);
    too_long = (cur.count > lttk_pkg::NAME_CNT_W'(lttk_pkg::MAX_NAME_CHARS));
    endt      = '0;
    endt.kind = lttk_pkg::KIND_END;
    endt.last = 1'b1;
    sym       = '0;
    sym.last  = 1'b1;
    sym_v     = 1'b1;
    case (in_byte)
      lttk_pkg::CH_LPAREN: sym.kind = lttk_pkg::KIND_LPAREN;
      lttk_pkg::CH_RPAREN: sym.kind = lttk_pkg::KIND_RPAREN;
      lttk_pkg::CH_DOT:    sym.kind = lttk_pkg::KIND_DOT;
      lttk_pkg::CH_BSLASH: sym.kind = lttk_pkg::KIND_BSLASH;
      lttk_pkg::CH_SPACE, lttk_pkg::CH_TAB, lttk_pkg::CH_CR, lttk_pkg::CH_LF: begin
        sym_v = 1'b0;
      end
      default: begin
        sym.kind = lttk_pkg::KIND_BADCHAR;
        sym.bad  = in_byte;
      end
    endcase

    if (in_byte == end_char) begin
      nxt.count  = '0;
      nxt.failed = 1'b0;
      if (!cur.failed && has_name) begin
        res.n      = 2'd2;
        res.first  = fl;
        res.second = endt;
      end else begin
        res.n     = 2'd1;
        res.first = endt;
      end
    end else if (!cur.failed) begin
      if (lttk_pkg::is_alnum(in_byte)) begin
        for (int i = 0; i < lttk_pkg::MAX_NAME_CHARS; i++) begin
          if (cur.count == lttk_pkg::NAME_CNT_W'(i)) begin
            nxt.chars[i] = in_byte;
          end
        end
        if (!too_long) begin
          nxt.count = cur.count + lttk_pkg::NAME_CNT_W'(1);
        end
      end else begin
        nxt.count = '0;
        if (too_long) begin
          res.n         = 2'd1;
          res.first     = fl;
          res.first.last = 1'b1;
          nxt.failed    = 1'b1;
        end else begin
          if (sym_v && sym.kind == lttk_pkg::KIND_BADCHAR) begin
            nxt.failed = 1'b1;
          end
          if (has_name && sym_v) begin
            res.n      = 2'd2;
            res.first  = fl;
            res.second = sym;
          end else if (has_name) begin
            res.n          = 2'd1;
            res.first      = fl;
            res.first.last = 1'b1;
          end else if (sym_v) begin
            res.n     = 2'd1;
            res.first = sym;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/lttk_outq.sv */
// Output token queue: takes up to two tokens a cycle while room is high, delivers one per pop.
`default_nettype none

`include "assert_macros.svh"

module lttk_outq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [1:0]       push_n,
  input  wire lttk_pkg::token_t push_a,
  input  wire lttk_pkg::token_t push_b,
  input  wire logic             pop,
  output logic                  room,
  output logic                  not_empty,
  output lttk_pkg::token_t      head
);

  lttk_pkg::token_t                    mem [lttk_pkg::OUTQ_DEPTH];
  logic [lttk_pkg::OUTQ_PTR_W-1:0]     wp;
  logic [lttk_pkg::OUTQ_PTR_W-1:0]     rp;
  logic [lttk_pkg::OUTQ_CNT_W-1:0]     count;

  assign room      = (count <= lttk_pkg::OUTQ_CNT_W'(lttk_pkg::OUTQ_DEPTH - 2));
  assign not_empty = (count != '0);
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + lttk_pkg::OUTQ_PTR_W'(push_n);
      rp    <= rp + lttk_pkg::OUTQ_PTR_W'(pop);
      count <= count + lttk_pkg::OUTQ_CNT_W'(push_n) - lttk_pkg::OUTQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wp] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem[wp + lttk_pkg::OUTQ_PTR_W'(1)] <= push_b;
    end
  end

  `LTT_ASSERT_ALWAYS(a_count_range, count <= lttk_pkg::OUTQ_CNT_W'(lttk_pkg::OUTQ_DEPTH), "queue count out of range")
  `LTT_ASSERT_IMPLIES(a_push_room, push_n != 2'd0, room, "push without room")
  `LTT_ASSERT_IMPLIES(a_pop_nonempty, pop, not_empty, "pop from empty queue")

endmodule

`default_nettype wire
